/* rtl/register_scrub_guard_assert.svh */
// assertion macros for the register scrub guard checks
`ifndef REGISTER_SCRUB_GUARD_ASSERT_SVH
`define REGISTER_SCRUB_GUARD_ASSERT_SVH

// same-cycle implication
`define RSG_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("register scrub guard check failed");

// next-cycle implication
`define RSG_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("register scrub guard check failed");

`endif

/* rtl/rsg_pkg.sv */
// types and constants shared by the register scrub guard
package rsg_pkg;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 7;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 16;
  localparam int CLS_W    = 2;
  localparam int ACT_W    = 2;
  localparam int CNT_W    = 32;
  localparam int REP_W    = 4;
  localparam int ECNT_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_SNAPSHOT = 3'd1,
    OP_VERIFY   = 3'd2,
    OP_HIDDEN   = 3'd3,
    OP_OUTCOME  = 3'd4
  } op_e;

  localparam logic [CLS_W-1:0] CLS_RESTORE    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_OR_RESTORE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_MONITOR    = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESTORE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MON_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_MASK  = 2'd2;

  localparam logic [REP_W-1:0]  MON_LIMIT_RST = 4'd4;
  localparam logic [REP_W-1:0]  HID_LIMIT_RST = 4'd8;
  localparam logic [DATA_W-1:0] HID_MASK_RST  = 16'h000F;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] register_address;
    logic [CLS_W-1:0]  entry_class;
    logic [ADDR_W-1:0] set_address;
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] raw_value;
    logic              write_ok;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] reg_addr;
    logic [ADDR_W-1:0] set_addr;
    logic [CLS_W-1:0]  cls;
    logic [DATA_W-1:0] snap;
    logic [CNT_W-1:0]  changes;
    logic [REP_W-1:0]  reports;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] heals;
    logic [CNT_W-1:0] monitor;
    logic [CNT_W-1:0] hidden;
    logic [REP_W-1:0] hid_reports;
  } tot_t;

  typedef struct packed {
    logic [REP_W-1:0]  mon_limit;
    logic [REP_W-1:0]  hid_limit;
    logic [DATA_W-1:0] hid_mask;
  } cfg_t;

  typedef struct packed {
    logic              deviated;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              report;
    logic [DATA_W-1:0] old_value;
    logic              hidden_detected;
    logic [CNT_W-1:0]  change_count;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic add_done;
  } upd_t;

endpackage

/* rtl/rsg_channels.sv */
// item and result channel interfaces of the register scrub guard
interface rsg_in_if import rsg_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  index;
  logic [ADDR_W-1:0] register_address;
  logic [CLS_W-1:0]  entry_class;
  logic [ADDR_W-1:0] set_address;
  logic [DATA_W-1:0] read_value;
  logic [DATA_W-1:0] raw_value;
  logic              write_ok;

  modport source (
    output valid, operation, index, register_address, entry_class, set_address,
           read_value, raw_value, write_ok,
    input  ready
  );
  modport sink (
    input  valid, operation, index, register_address, entry_class, set_address,
           read_value, raw_value, write_ok,
    output ready
  );
endinterface

interface rsg_out_if import rsg_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              deviated;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] write_address;
  logic [DATA_W-1:0] write_data;
  logic              report;
  logic [DATA_W-1:0] old_value;
  logic              hidden_detected;
  logic [CNT_W-1:0]  change_count;
  logic [CNT_W-1:0]  heal_total;
  logic [CNT_W-1:0]  monitor_total;
  logic [CNT_W-1:0]  hidden_total;
  logic [ECNT_W-1:0] entry_count;

  modport source (
    output valid, deviated, action, write_address, write_data, report, old_value,
           hidden_detected, change_count, heal_total, monitor_total, hidden_total,
           entry_count,
    input  ready
  );
  modport sink (
    input  valid, deviated, action, write_address, write_data, report, old_value,
           hidden_detected, change_count, heal_total, monitor_total, hidden_total,
           entry_count,
    output ready
  );
endinterface

/* rtl/rsg_table_mem.sv */
// watched register table: one write port, one registered read port
module rsg_table_mem import rsg_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output entry_t                   rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  entry_t                   wr_data_i
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/rsg_datapath.sv */
// per-item update of one table entry and the running totals
module rsg_datapath import rsg_pkg::*; (
  input  item_t  item_i,
  input  entry_t entry_i,
  input  logic   entry_ok_i,
  input  logic   add_ok_i,
  input  tot_t   tot_i,
  input  cfg_t   cfg_i,
  output entry_t entry_o,
  output tot_t   tot_o,
  output res_t   res_o,
  output upd_t   upd_o
);

  logic hit;

  assign hit = |(item_i.raw_value & cfg_i.hid_mask & ~item_i.read_value);

  always_comb begin
    entry_o = entry_i;
    tot_o   = tot_i;
    res_o   = '0;
    upd_o   = '0;
    case (op_e'(item_i.operation))
      OP_ADD: begin
        if (add_ok_i) begin
          upd_o.wr_en      = 1'b1;
          upd_o.add_done   = 1'b1;
          entry_o.reg_addr = item_i.register_address;
          entry_o.set_addr = item_i.set_address;
          entry_o.cls      = item_i.entry_class;
          entry_o.changes  = '0;
          entry_o.reports  = '0;
        end
      end
      OP_SNAPSHOT: begin
        if (entry_ok_i) begin
          upd_o.wr_en        = 1'b1;
          res_o.old_value    = entry_i.snap;
          res_o.change_count = entry_i.changes;
          entry_o.snap       = item_i.read_value;
        end
      end
      OP_VERIFY: begin
        if (entry_ok_i) begin
          res_o.old_value    = entry_i.snap;
          res_o.change_count = entry_i.changes;
          if (item_i.read_value != entry_i.snap) begin
            upd_o.wr_en        = 1'b1;
            res_o.deviated     = 1'b1;
            entry_o.changes    = entry_i.changes + 32'd1;
            res_o.change_count = entry_i.changes + 32'd1;
            case (entry_i.cls)
              CLS_RESTORE: begin
                res_o.action        = ACT_RESTORE;
                res_o.write_address = entry_i.reg_addr;
                res_o.write_data    = entry_i.snap;
                res_o.report        = 1'b1;
              end
              CLS_OR_RESTORE: begin
                res_o.action        = ACT_SET;
                res_o.write_address = entry_i.set_addr;
                res_o.write_data    = entry_i.snap & ~item_i.read_value;
                res_o.report        = 1'b1;
              end
              CLS_MONITOR: begin
                tot_o.monitor = tot_i.monitor + 32'd1;
                if (entry_i.reports < cfg_i.mon_limit) begin
                  entry_o.reports = entry_i.reports + 4'd1;
                  res_o.report    = 1'b1;
                end
                entry_o.snap = item_i.read_value;
              end
              default: ;
            endcase
          end
        end
      end
      OP_HIDDEN: begin
        if (hit) begin
          res_o.hidden_detected = 1'b1;
          tot_o.hidden          = tot_i.hidden + 32'd1;
          if (tot_i.hid_reports < cfg_i.hid_limit) begin
            tot_o.hid_reports = tot_i.hid_reports + 4'd1;
            res_o.report      = 1'b1;
          end
        end
      end
      OP_OUTCOME: begin
        if (entry_ok_i) begin
          res_o.old_value    = entry_i.snap;
          res_o.change_count = entry_i.changes;
          if (entry_i.cls == CLS_RESTORE || entry_i.cls == CLS_OR_RESTORE) begin
            if (item_i.write_ok &&
                (entry_i.cls == CLS_OR_RESTORE || item_i.read_value == entry_i.snap)) begin
              tot_o.heals = tot_i.heals + 32'd1;
            end else begin
              res_o.report = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/register_scrub_guard.sv */
// top level of the register scrub guard
//
//   channel   | dir | handshake        | content
//   item_i    | in  | valid / ready    | one operation on the table or status
//   result_o  | out | valid / ready    | heal request, report flags, totals
//   cfg_*_i   | in  | write enable     | report limits and hidden watch mask
//
// an item is read from the table on the transfer, then modified and written back
// a new item is not taken until the single read-modify-write of the last one is done
// the next item is taken while a result waits, the update stalls until the result leaves
// reset clears the entry count and totals and loads the default limits and mask at once
// table words are written on add, on snapshot and on a verify that finds a deviation
module register_scrub_guard import rsg_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rsg_in_if.sink                item_i,
  rsg_out_if.source             result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (UW > IDX_W) ? UW : IDX_W;

  cfg_t          cfg_q;
  tot_t          tot_q, tot_d;
  logic [UW-1:0] used_q;
  logic          busy_q;
  logic          out_valid_q;
  item_t         item_q, item_in;
  logic [IW-1:0] addr_q, rd_addr;
  res_t          res_q, res_d;
  entry_t        entry_rd, entry_wr;
  upd_t          upd;
  logic          accept, done, entry_ok, add_ok;

  assign item_in = '{
    operation:        item_i.operation,
    index:            item_i.index,
    register_address: item_i.register_address,
    entry_class:      item_i.entry_class,
    set_address:      item_i.set_address,
    read_value:       item_i.read_value,
    raw_value:        item_i.raw_value,
    write_ok:         item_i.write_ok
  };

  assign item_i.ready = !busy_q;
  assign accept       = item_i.valid && !busy_q;
  assign done         = busy_q && (!out_valid_q || result_o.ready);

  assign rd_addr  = (op_e'(item_i.operation) == OP_ADD) ? used_q[IW-1:0] : IW'(item_i.index);
  assign entry_ok = CW'(item_q.index) < CW'(used_q);
  assign add_ok   = used_q != UW'(TABLE_DEPTH);

  rsg_table_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (entry_rd),
    .wr_en_i   (done && upd.wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (entry_wr)
  );

  rsg_datapath u_dp (
    .item_i     (item_q),
    .entry_i    (entry_rd),
    .entry_ok_i (entry_ok),
    .add_ok_i   (add_ok),
    .tot_i      (tot_q),
    .cfg_i      (cfg_q),
    .entry_o    (entry_wr),
    .tot_o      (tot_d),
    .res_o      (res_d),
    .upd_o      (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mon_limit <= MON_LIMIT_RST;
      cfg_q.hid_limit <= HID_LIMIT_RST;
      cfg_q.hid_mask  <= HID_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MON_LIMIT: cfg_q.mon_limit <= cfg_data_i[REP_W-1:0];
        CFG_HID_LIMIT: cfg_q.hid_limit <= cfg_data_i[REP_W-1:0];
        CFG_HID_MASK:  cfg_q.hid_mask  <= cfg_data_i[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      tot_q       <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
        tot_q       <= tot_d;
        if (upd.add_done) begin
          used_q <= used_q + UW'(1);
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_in;
      addr_q <= rd_addr;
    end
    if (done) begin
      res_q <= res_d;
    end
  end

  // totals and count only move on an update, which waits for the result to leave
  assign result_o.valid           = out_valid_q;
  assign result_o.deviated        = res_q.deviated;
  assign result_o.action          = res_q.action;
  assign result_o.write_address   = res_q.write_address;
  assign result_o.write_data      = res_q.write_data;
  assign result_o.report          = res_q.report;
  assign result_o.old_value       = res_q.old_value;
  assign result_o.hidden_detected = res_q.hidden_detected;
  assign result_o.change_count    = res_q.change_count;
  assign result_o.heal_total      = tot_q.heals;
  assign result_o.monitor_total   = tot_q.monitor;
  assign result_o.hidden_total    = tot_q.hidden;
  assign result_o.entry_count     = ECNT_W'(used_q);

endmodule

/* rtl/rsg_checker.sv */
// port-level checks of the register scrub guard and their binding
`include "register_scrub_guard_assert.svh"

module rsg_checker import rsg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic              deviated,
  input logic [ACT_W-1:0]  action,
  input logic              report,
  input logic              hidden_detected,
  input logic [DATA_W-1:0] write_data,
  input logic [DATA_W-1:0] old_value
);

  `RSG_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(old_value))
  `RSG_ASSERT_IMPL(a_heal_reported, clk_i, rst_ni, out_valid && action != ACT_NONE, deviated && report)
  `RSG_ASSERT_IMPL(a_hidden_alone, clk_i, rst_ni, out_valid && hidden_detected, !deviated && action == ACT_NONE)
  `RSG_ASSERT_IMPL(a_restore_data, clk_i, rst_ni, out_valid && action == ACT_RESTORE, write_data == old_value)

endmodule

bind register_scrub_guard rsg_checker u_rsg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (result_o.valid),
  .out_ready       (result_o.ready),
  .deviated        (result_o.deviated),
  .action          (result_o.action),
  .report          (result_o.report),
  .hidden_detected (result_o.hidden_detected),
  .write_data      (result_o.write_data),
  .old_value       (result_o.old_value)
);
